/* hdl/psm_pkg.sv */
// ----------------------------------------------------------------------------
// psm_pkg - pixel statistics merge package
// shared widths and constants between sequencer and datapath
// ----------------------------------------------------------------------------
package psm_pkg;
  localparam int CountW = 25;
  localparam int PixW   = 16;
  localparam int MeanW  = 32;
  localparam int SumW   = 40;
  localparam int SqW    = 56;
  localparam int M2W    = 64;
  localparam int VarW   = 48;
  localparam int SdW    = 32;
  localparam int M2Frac = 8;

  localparam int DefMaxPixels = 16777216;
  localparam int DefPixelBits = 16;
  localparam int DefFracBits  = 16;

  // width of the working register for wide products and dividends
  localparam int WideW = 128;

  // serial unit operations
  localparam logic [1:0] OpMul  = 2'd0;
  localparam logic [1:0] OpDiv  = 2'd1;
  localparam logic [1:0] OpSqrt = 2'd2;

  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [SqW-1:0]  SqMax  = {SqW{1'b1}};
  localparam logic [M2W-1:0]  M2Max  = {M2W{1'b1}};
  localparam logic [VarW-1:0] VarMax = {VarW{1'b1}};
  localparam logic [MeanW-1:0] MeanMax = {MeanW{1'b1}};
endpackage

/* hdl/psm_serial_unit.sv */
// ----------------------------------------------------------------------------
// psm_serial_unit - shared bit-serial multiply, divide and square root
// one bit of result per cycle; start with op, operands; done pulses once
// ----------------------------------------------------------------------------
module psm_serial_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [1:0]                 op,     // 0 mul, 1 div, 2 sqrt
  input  logic [psm_pkg::WideW-1:0]  a,      // multiplicand, dividend or radicand
  input  logic [63:0]                b,      // multiplier or divisor
  output logic                       done,
  output logic [psm_pkg::WideW-1:0]  res
);
  import psm_pkg::*;

  logic             busy;
  logic [1:0]       cur_op;
  logic [7:0]       cnt;
  logic [WideW-1:0] acc;    // product, quotient or root
  logic [WideW-1:0] sh;     // shifting operand
  logic [WideW:0]   rem;    // remainder
  logic [63:0]      bsh;

  logic [WideW:0] trial;
  logic [WideW:0] rem_sh;
  logic [WideW+1:0] rem_sq;
  logic [WideW+1:0] trial_sq;

  always_comb begin
    rem_sh   = {rem[WideW-1:0], sh[WideW-1]};
    trial    = rem_sh - {{(WideW-63){1'b0}}, bsh};
    rem_sq   = {rem[WideW-1:0], sh[WideW-1:WideW-2]};
    trial_sq = rem_sq - {acc[WideW-1:0], 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy   <= 1'b1;
        cur_op <= op;
        sh     <= a;
        bsh    <= b;
        acc    <= '0;
        rem    <= '0;
        cnt    <= (op == OpSqrt) ? 8'(WideW/2) : (op == OpMul) ? 8'd64 : 8'(WideW);
      end else if (busy) begin
        unique case (cur_op)
          OpMul: begin
            // shift-add, multiplier lsb first
            if (bsh[0]) acc <= acc + (sh << (64 - cnt));
            bsh <= bsh >> 1;
          end
          OpDiv: begin
            sh <= sh << 1;
            if (!trial[WideW]) begin
              rem <= trial;
              acc <= {acc[WideW-2:0], 1'b1};
            end else begin
              rem <= rem_sh;
              acc <= {acc[WideW-2:0], 1'b0};
            end
          end
          default: begin
            sh <= sh << 2;
            if (!trial_sq[WideW+1]) begin
              rem <= trial_sq[WideW:0];
              acc <= {acc[WideW-2:0], 1'b1};
            end else begin
              rem <= rem_sq[WideW:0];
              acc <= {acc[WideW-2:0], 1'b0};
            end
          end
        endcase
        cnt <= cnt - 8'd1;
        if (cnt == 8'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = acc;
endmodule

/* hdl/pixel_stats_merge.sv */
// ----------------------------------------------------------------------------
// pixel_stats_merge - running merge of partial pixel-statistics records
//
// s_axis carries one partial record per request (mode 0 as sums, mode 1 as
// mean and second moment); m_axis returns the merged totals, variance and
// standard deviation, one result per record.
// A record is taken only when the block is idle; a sequencer then drives one
// shared bit-serial unit (multiply, divide and square root) over the steps of
// the load and the merge. An empty record takes the shortest path; a true
// merge of a mode 0 record with a valid variance takes the longest.
// The result sits in an output register until m_axis_tready; no new record is
// accepted while it waits. Reset clears the totals and the sequencer.
// ----------------------------------------------------------------------------
module pixel_stats_merge #(
  parameter int MAX_PIXELS = psm_pkg::DefMaxPixels,
  parameter int PIXEL_BITS = psm_pkg::DefPixelBits,
  parameter int FRAC_BITS  = psm_pkg::DefFracBits
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // part_count, part_min, part_max, part_sum, part_sum_sq, part_mean,
  // part_second_moment, zero fill to 256 bits
  input  logic [255:0] s_axis_tdata,
  // start_req, mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // total_count, total_min, total_max, total_mean, total_sum, total_sum_sq,
  // total_second_moment, variance_out, std_dev, variance_valid, is_empty, zero fill
  output logic [335:0] m_axis_tdata
);
  import psm_pkg::*;

  localparam logic [CountW-1:0] MaxCnt = CountW'(MAX_PIXELS);

  localparam logic [4:0] S_IDLE = 5'd0,  S_L0 = 5'd1,  S_L1 = 5'd2,  S_L2 = 5'd3,
                         S_L3 = 5'd4,    S_L4 = 5'd5,  S_L5 = 5'd6,  S_V0 = 5'd7,
                         S_V1 = 5'd8,    S_M0 = 5'd9,  S_M1 = 5'd10, S_M2 = 5'd11,
                         S_M3 = 5'd12,   S_M4 = 5'd13, S_M5 = 5'd14, S_M6 = 5'd15,
                         S_DONE = 5'd16, S_OUT = 5'd17, S_F0 = 5'd18;

  logic [4:0] state;
  logic [4:0] ret;   // where the variance steps (S_F0, S_V1, S_M6) return

  // accumulated totals
  logic [CountW-1:0] a_n;
  logic [PixW-1:0]   a_mn, a_mx;
  logic [MeanW-1:0]  a_mean;
  logic [SumW-1:0]   a_sum;
  logic [SqW-1:0]    a_sq;
  logic [M2W-1:0]    a_m2;
  logic [VarW-1:0]   a_var;
  logic [SdW-1:0]    a_sd;
  logic              a_valid;

  // loaded record
  logic              mode;
  logic [CountW-1:0] r_n;
  logic [PixW-1:0]   r_mn, r_mx;
  logic [MeanW-1:0]  r_mean;
  logic [SumW-1:0]   r_sum;
  logic [SqW-1:0]    r_sq;
  logic [M2W-1:0]    r_m2;
  logic [VarW-1:0]   r_var;
  logic [SdW-1:0]    r_sd;
  logic              r_valid;
  logic [WideW-1:0]  t0;      // scratch
  logic [25:0]       nab;

  // serial unit
  logic             u_start, u_done;
  logic [1:0]       u_op;
  logic [WideW-1:0] u_a, u_res;
  logic [63:0]      u_b;

  psm_serial_unit u_ser (
    .clk(clk), .rst(rst), .start(u_start), .op(u_op), .a(u_a), .b(u_b),
    .done(u_done), .res(u_res)
  );

  logic [CountW-1:0] in_n;
  logic [M2W-1:0]    var_m2;
  logic [25:0]       var_n;
  logic [MeanW-1:0]  dmean;
  always_comb begin
    in_n  = (s_axis_tdata[24:0] > MaxCnt) ? MaxCnt : s_axis_tdata[24:0];
    dmean = (r_mean > a_mean) ? r_mean - a_mean : a_mean - r_mean;
    var_m2 = (ret == S_DONE) ? a_m2 : r_m2;
    var_n  = (ret == S_DONE) ? nab : {1'b0, r_n};
  end

  function automatic logic [WideW-1:0] sadd(logic [WideW-1:0] x, logic [WideW-1:0] y,
                                            logic [WideW-1:0] mx);
    logic [WideW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s > {1'b0, mx}) ? mx : s[WideW-1:0];
  endfunction

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; u_start <= 1'b0; m_axis_tvalid <= 1'b0;
      a_n <= '0; a_mn <= '0; a_mx <= '0; a_mean <= '0; a_sum <= '0; a_sq <= '0;
      a_m2 <= '0; a_var <= '0; a_sd <= '0; a_valid <= 1'b0; ret <= S_IDLE;
    end else begin
      u_start <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          if (s_axis_tuser[0]) begin
            a_n <= '0; a_mn <= '0; a_mx <= '0; a_mean <= '0; a_sum <= '0;
            a_sq <= '0; a_m2 <= '0; a_var <= '0; a_sd <= '0; a_valid <= 1'b0;
          end
          mode   <= s_axis_tuser[1];
          r_n    <= in_n;
          r_mn   <= PixW'(s_axis_tdata[40:25] & PixW'((1 << PIXEL_BITS) - 1));
          r_mx   <= PixW'(s_axis_tdata[56:41] & PixW'((1 << PIXEL_BITS) - 1));
          r_sum  <= s_axis_tdata[96:57];
          r_sq   <= s_axis_tdata[152:97];
          r_mean <= s_axis_tdata[184:153];
          r_m2   <= s_axis_tdata[248:185];
          r_valid <= 1'b0; r_var <= '0; r_sd <= '0;
          state  <= (in_n == '0) ? S_OUT : S_L0;
        end
        S_L0: begin
          u_start <= 1'b1;
          if (!mode) begin // sum << F / n
            u_op <= OpDiv; u_a <= WideW'(r_sum) << FRAC_BITS; u_b <= 64'(r_n);
          end else begin   // n*mean
            u_op <= OpMul; u_a <= WideW'(r_mean); u_b <= 64'(r_n);
          end
          state <= S_L1;
        end
        S_L1: if (u_done) begin
          u_start <= 1'b1;
          if (!mode) begin
            r_mean <= (u_res > WideW'(MeanMax)) ? MeanMax : u_res[MeanW-1:0];
            u_op <= OpMul; u_a <= WideW'(r_sq); u_b <= 64'(r_n);
          end else begin
            t0 <= u_res >> FRAC_BITS;
            u_op <= OpMul; u_a <= WideW'(r_mean); u_b <= 64'(r_mean);
          end
          state <= S_L2;
        end
        S_L2: if (u_done) begin
          u_start <= 1'b1;
          if (!mode) begin
            t0 <= u_res;
            u_op <= OpMul; u_a <= WideW'(r_sum); u_b <= 64'(r_sum);
          end else begin
            r_sum <= (t0 > WideW'(SumMax)) ? SumMax : t0[SumW-1:0];
            u_op <= OpMul; u_a <= u_res; u_b <= 64'(r_n);
          end
          state <= S_L3;
        end
        S_L3: if (u_done) begin
          if (!mode) begin
            if (t0 < u_res) begin
              r_m2 <= '0; state <= S_V0;
            end else begin
              u_start <= 1'b1; u_op <= OpDiv;
              u_a <= (t0 - u_res) << M2Frac; u_b <= 64'(r_n);
              state <= S_L4;
            end
          end else begin
            r_sq <= ((u_res >> (2 * FRAC_BITS)) > WideW'(SqMax)) ? SqMax
                    : SqW'(u_res >> (2 * FRAC_BITS));
            state <= S_V0;
          end
        end
        S_L4: if (u_done) begin
          r_m2 <= (u_res > WideW'(M2Max)) ? M2Max : u_res[M2W-1:0];
          state <= S_V0;
        end
        S_V0: begin
          if (r_n >= CountW'(2) && r_m2 != '0) begin
            r_valid <= 1'b1; ret <= S_M0; state <= S_F0;
          end else state <= S_M0;
        end
        // variance: (m2 << F-8) / n, then isqrt(var << F)
        S_F0: begin
          u_start <= 1'b1; u_op <= OpDiv;
          u_a <= WideW'(var_m2) << (FRAC_BITS - M2Frac); u_b <= 64'(var_n);
          state <= S_V1;
        end
        S_V1: if (u_done) begin
          u_start <= 1'b1; u_op <= OpSqrt;
          t0 <= (u_res > WideW'(VarMax)) ? WideW'(VarMax) : u_res;
          u_a <= ((u_res > WideW'(VarMax)) ? WideW'(VarMax) : u_res) << FRAC_BITS;
          state <= S_M6;
        end
        S_M6: if (u_done) begin
          if (ret == S_DONE) begin
            a_var <= t0[VarW-1:0]; a_sd <= u_res[SdW-1:0];
          end else begin
            r_var <= t0[VarW-1:0]; r_sd <= u_res[SdW-1:0];
          end
          state <= ret;
        end
        S_M0: begin
          if (a_n == '0) begin
            a_n <= r_n; a_mn <= r_mn; a_mx <= r_mx; a_mean <= r_mean; a_sum <= r_sum;
            a_sq <= r_sq; a_m2 <= r_m2; a_var <= r_var; a_sd <= r_sd;
            a_valid <= r_valid; state <= S_OUT;
          end else begin
            nab <= {1'b0, a_n} + {1'b0, r_n};
            if (r_mn < a_mn) a_mn <= r_mn;
            if (r_mx > a_mx) a_mx <= r_mx;
            a_sum <= SumW'(sadd(WideW'(a_sum), WideW'(r_sum), WideW'(SumMax)));
            a_sq  <= SqW'(sadd(WideW'(a_sq), WideW'(r_sq), WideW'(SqMax)));
            u_start <= 1'b1; u_op <= OpMul; u_a <= WideW'(a_n); u_b <= 64'(a_mean);
            state <= S_M1;
          end
        end
        S_M1: if (u_done) begin
          t0 <= u_res;
          u_start <= 1'b1; u_op <= OpMul; u_a <= WideW'(r_n); u_b <= 64'(r_mean);
          state <= S_M2;
        end
        S_M2: if (u_done) begin
          u_start <= 1'b1; u_op <= OpDiv; u_a <= t0 + u_res; u_b <= 64'(nab);
          state <= S_M3;
        end
        S_M3: if (u_done) begin
          t0 <= u_res; // new mean, held until m2 uses old mean
          u_start <= 1'b1; u_op <= OpMul; u_a <= WideW'(dmean); u_b <= 64'(dmean);
          state <= S_M4;
        end
        S_M4: if (u_done) begin
          a_mean <= t0[MeanW-1:0];
          t0 <= u_res;
          u_start <= 1'b1; u_op <= OpMul; u_a <= WideW'(a_n); u_b <= 64'(r_n);
          state <= S_M5;
        end
        S_M5: if (u_done) begin
          // d*d*na*nb fits: 64 x 50 bits
          u_start <= 1'b1; u_op <= OpMul; u_a <= t0; u_b <= u_res[63:0];
          state <= S_DONE + 5'd0 == S_DONE ? S_L5 : S_L5;
        end
        S_L5: if (u_done) begin
          u_start <= 1'b1; u_op <= OpDiv; u_a <= u_res; u_b <= 64'(nab);
          state <= S_L5 + 5'd0 == S_L5 ? S_DONE - 5'd0 : S_DONE;
          ret <= S_IDLE;
        end
        S_DONE: begin
          if (ret == S_IDLE) begin
            if (u_done) begin
              a_m2 <= M2W'(sadd(sadd(WideW'(a_m2), WideW'(r_m2), WideW'(M2Max)),
                   ((u_res >> (2 * FRAC_BITS - M2Frac)) > WideW'(M2Max)) ? WideW'(M2Max)
                   : (u_res >> (2 * FRAC_BITS - M2Frac)), WideW'(M2Max)));
              a_valid <= 1'b1;
              a_n <= (nab > {1'b0, MaxCnt}) ? MaxCnt : nab[CountW-1:0];
              ret <= S_DONE; state <= S_F0;
            end
          end else state <= S_OUT;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          if (m_axis_tvalid && m_axis_tready) begin
            m_axis_tvalid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {
    5'd0,
    (a_n == '0),
    a_valid,
    a_valid ? a_sd : {SdW{1'b0}},
    a_valid ? a_var : {VarW{1'b0}},
    a_m2, a_sq, a_sum, a_mean, a_mx, a_mn, a_n
  };
endmodule

/* bench/pixel_stats_merge_tb.sv */
// ----------------------------------------------------------------------------
// pixel_stats_merge_tb - self-checking bench for the pixel statistics merge
//
// Partial records go in as sums or as mean and second moment. A predictor
// in the bench keeps its own running totals and works out the expected
// totals, variance and standard deviation for every request. Each result
// is compared field by field against the oldest expected result. Directed
// corner records run first, then a held-off receiver, then random records
// under three idle mixes.
// ----------------------------------------------------------------------------
module pixel_stats_merge_tb;
  import psm_pkg::*;

  localparam int MaxPixels    = DefMaxPixels;
  localparam int FracBits     = DefFracBits;
  localparam int WatchdogMax  = 20000;
  localparam int HoldCycles   = 3000;
  localparam int DrainCycles  = 2000;

  typedef struct packed {
    logic              start;
    logic              mode;
    logic [CountW-1:0] count;
    logic [PixW-1:0]   mn;
    logic [PixW-1:0]   mx;
    logic [SumW-1:0]   sum;
    logic [SqW-1:0]    sum_sq;
    logic [MeanW-1:0]  mean;
    logic [M2W-1:0]    m2;
  } part_rec_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [PixW-1:0]   mn;
    logic [PixW-1:0]   mx;
    logic [MeanW-1:0]  mean;
    logic [SumW-1:0]   sum;
    logic [SqW-1:0]    sum_sq;
    logic [M2W-1:0]    m2;
    logic [VarW-1:0]   variance;
    logic [SdW-1:0]    sd;
    logic              valid;
    logic              empty;
  } totals_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [335:0] m_axis_tdata;

  totals_t running;
  totals_t expected_totals[$];
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_left = 0;
  int      quiet_cycles = 0;
  int      errors = 0;

  pixel_stats_merge i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  function automatic logic [127:0] clip(input logic [127:0] x, input int w);
    logic [127:0] top;
    top = (128'(1) << w) - 1;
    return (x > top) ? top : x;
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] r, b, left;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    left = v;
    while (b > left) b = b >> 2;
    while (b != 0) begin
      if (left >= r + b) begin
        left = left - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void spread(input logic [63:0] m2, input logic [127:0] n,
                                 output logic [VarW-1:0] variance, output logic [SdW-1:0] sd);
    logic [127:0] w;
    logic [63:0]  v;
    w = (128'(m2) << (FracBits - M2Frac)) / n;
    v = 64'(clip(w, VarW));
    variance = v[VarW-1:0];
    sd = 32'(floor_sqrt(v << FracBits));
  endfunction

  // turns one request into its own totals form
  function automatic totals_t load_part(input part_rec_t p);
    totals_t      t;
    logic [127:0] n, a, b, w;
    t = '0;
    n = (p.count > MaxPixels) ? 128'(MaxPixels) : 128'(p.count);
    t.count = n[CountW-1:0];
    t.mn = p.mn;
    t.mx = p.mx;
    if (n == 0) return t;
    if (p.mode == 1'b0) begin
      t.sum = p.sum;
      t.sum_sq = p.sum_sq;
      t.mean = 32'(clip((128'(p.sum) << FracBits) / n, MeanW));
      a = 128'(p.sum_sq) * n;
      b = 128'(p.sum) * 128'(p.sum);
      if (a < b) t.m2 = '0;
      else t.m2 = 64'(clip(((a - b) << M2Frac) / n, M2W));
    end else begin
      t.mean = p.mean;
      t.sum = 40'(clip((n * 128'(p.mean)) >> FracBits, SumW));
      w = 128'(p.mean) * 128'(p.mean) * n;
      t.sum_sq = 56'(clip(w >> (2 * FracBits), SqW));
      t.m2 = p.m2;
    end
    if (n >= 2 && t.m2 != 0) begin
      t.valid = 1'b1;
      spread(t.m2, n, t.variance, t.sd);
    end
    return t;
  endfunction

  function automatic totals_t merge_totals(input totals_t acc, input part_rec_t p);
    totals_t      r, m;
    logic [127:0] na, nb, nab, d, extra, m2;
    m = acc;
    if (p.start) m = '0;
    r = load_part(p);
    if (r.count != 0) begin
      if (m.count == 0) begin
        m = r;
      end else begin
        na = 128'(m.count);
        nb = 128'(r.count);
        nab = na + nb;
        d = (r.mean > m.mean) ? 128'(r.mean - m.mean) : 128'(m.mean - r.mean);
        if (r.mn < m.mn) m.mn = r.mn;
        if (r.mx > m.mx) m.mx = r.mx;
        m.sum = 40'(clip(128'(m.sum) + 128'(r.sum), SumW));
        m.sum_sq = 56'(clip(128'(m.sum_sq) + 128'(r.sum_sq), SqW));
        m.mean = 32'((na * 128'(m.mean) + nb * 128'(r.mean)) / nab);
        extra = clip(((d * d * na * nb) / nab) >> (2 * FracBits - M2Frac), M2W);
        m2 = clip(clip(128'(m.m2) + 128'(r.m2), M2W) + extra, M2W);
        m.m2 = m2[63:0];
        spread(m.m2, nab, m.variance, m.sd);
        m.valid = 1'b1;
        m.count = (nab > MaxPixels) ? CountW'(MaxPixels) : nab[CountW-1:0];
      end
    end
    m.empty = (m.count == 0);
    return m;
  endfunction

  task automatic send_part(input part_rec_t p);
    totals_t shown;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'b0, p.m2, p.mean, p.sum_sq, p.sum, p.mx, p.mn, p.count};
    s_axis_tuser <= {p.mode, p.start};
    do @(posedge clk); while (!s_axis_tready);
    running = merge_totals(running, p);
    shown = running;
    if (!shown.valid) begin
      shown.variance = '0;
      shown.sd = '0;
    end
    expected_totals.push_back(shown);
  endtask

  function automatic part_rec_t mk(input logic start, input logic mode,
                                   input logic [CountW-1:0] count,
                                   input logic [PixW-1:0] mn, input logic [PixW-1:0] mx,
                                   input logic [SumW-1:0] sum, input logic [SqW-1:0] sum_sq,
                                   input logic [MeanW-1:0] mean, input logic [M2W-1:0] m2);
    part_rec_t p;
    p.start = start; p.mode = mode; p.count = count; p.mn = mn; p.mx = mx;
    p.sum = sum; p.sum_sq = sum_sq; p.mean = mean; p.m2 = m2;
    return p;
  endfunction

  // mostly self-consistent records, with some full-range noise
  function automatic part_rec_t random_part();
    part_rec_t    p;
    logic [15:0]  pix;
    logic [127:0] w;
    int           pick;
    p.start = ($urandom_range(7) == 0);
    p.mode = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 15) p.count = CountW'($urandom_range(3));
    else if (pick < 80) p.count = CountW'($urandom_range(4096, 1));
    else if (pick < 90) p.count = CountW'($urandom_range(MaxPixels, MaxPixels - 8));
    else p.count = CountW'($urandom);
    p.mn = 16'($urandom);
    p.mx = 16'($urandom);
    pix = 16'($urandom);
    if ($urandom_range(3) != 0) begin
      w = 128'(p.count) * 128'(pix);
      p.sum = w[SumW-1:0];
      w = w * 128'(pix) + 128'($urandom_range(1 << 20));
      p.sum_sq = w[SqW-1:0];
    end else begin
      p.sum = SumW'({$urandom, $urandom});
      p.sum_sq = SqW'({$urandom, $urandom});
    end
    p.mean = ($urandom_range(3) != 0) ? {pix, 16'($urandom)} : 32'($urandom);
    case ($urandom_range(3))
      0: p.m2 = {$urandom, $urandom};
      1: p.m2 = 64'($urandom);
      2: p.m2 = '0;
      default: p.m2 = {$urandom, $urandom} >> $urandom_range(63);
    endcase
    return p;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    totals_t ex;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_totals.size() == 0) begin
        $display("%0t: result with nothing expected, actual %0h", $time, m_axis_tdata);
        errors++;
      end else begin
        ex = expected_totals.pop_front();
        check_field("total_count", 64'(ex.count), 64'(m_axis_tdata[24:0]));
        check_field("total_min", 64'(ex.mn), 64'(m_axis_tdata[40:25]));
        check_field("total_max", 64'(ex.mx), 64'(m_axis_tdata[56:41]));
        check_field("total_mean", 64'(ex.mean), 64'(m_axis_tdata[88:57]));
        check_field("total_sum", 64'(ex.sum), 64'(m_axis_tdata[128:89]));
        check_field("total_sum_sq", 64'(ex.sum_sq), 64'(m_axis_tdata[184:129]));
        check_field("total_second_moment", ex.m2, m_axis_tdata[248:185]);
        check_field("variance_out", 64'(ex.variance), 64'(m_axis_tdata[296:249]));
        check_field("std_dev", 64'(ex.sd), 64'(m_axis_tdata[328:297]));
        check_field("variance_valid", 64'(ex.valid), 64'(m_axis_tdata[329]));
        check_field("is_empty", 64'(ex.empty), 64'(m_axis_tdata[330]));
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= WatchdogMax) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_corners();
    logic [M2W-1:0] full64;
    full64 = '1;
    // single pixel, no variance
    send_part(mk(1, 0, 1, 100, 100, 100, 10000, 0, 0));
    // empty record on loaded totals, then clear into empty
    send_part(mk(0, 0, 0, 5, 5, 5, 5, 5, 5));
    send_part(mk(1, 1, 0, 0, 0, 0, 0, 0, 0));
    send_part(mk(0, 0, 0, '1, '1, '1, '1, '1, '1));
    // copy into empty totals, then a true merge
    send_part(mk(0, 0, 4, 10, 40, 100, 3000, 0, 0));
    send_part(mk(0, 1, 3, 2, 9, 0, 0, 32'h0005_8000, 64'h300));
    // sum of squares below sum squared gives a zero second moment
    send_part(mk(1, 0, 4, 1, 2, 100, 10, 0, 0));
    // mode 1 with zero second moment on two pixels
    send_part(mk(1, 1, 2, 7, 7, 0, 0, 32'h0007_0000, 0));
    // count above the ceiling is clamped
    send_part(mk(1, 0, '1, 0, '1, '1, '1, 0, 0));
    send_part(mk(0, 1, '1, 0, '1, 0, 0, '1, full64));
    // saturation of everything at the ceiling
    send_part(mk(1, 1, MaxPixels, 0, '1, 0, 0, '1, full64));
    send_part(mk(0, 1, MaxPixels, '1, 0, 0, 0, 0, full64));
    send_part(mk(0, 0, 2, 0, '1, '1, '1, 0, 0));
    send_part(mk(1, 1, 1, '1, '1, 0, 0, '1, full64));
    send_part(mk(0, 0, MaxPixels, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = HoldCycles;
    repeat (6) send_part(random_part());
  endtask

  task automatic test_random(input int n_parts, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (n_parts) send_part(random_part());
  endtask

  initial begin
    running = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    test_output_stall();
    test_random(230, 27, 76);
    test_random(230, 76, 27);
    test_random(230, 0, 0);
    s_axis_tvalid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0 && expected_totals.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
